// ===== src/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Width of one color component; saturation and brightness share it.
  localparam int COMPONENT_BITS = 8;
  localparam int FULL_SCALE = (1 << COMPONENT_BITS) - 1;

  localparam int HUE_W = 9;
  // Signed width that holds every hue before the wrap into 0..359.
  localparam int HUE_SUM_W = 10;

  // Quotient bits of both dividers: saturation needs COMPONENT_BITS bits,
  // and the hue fraction reaches 60, which needs six.
  localparam int QUO_W = (COMPONENT_BITS > 6) ? COMPONENT_BITS : 6;
  localparam int REM_W = COMPONENT_BITS + QUO_W;

  localparam int DEG_SECTOR = 60;
  localparam int DEG_GREEN  = 120;
  localparam int DEG_BLUE   = 240;
  localparam int DEG_FULL   = 360;

  typedef logic [COMPONENT_BITS-1:0] comp_t;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    comp_t            saturation;
    comp_t            brightness;
  } hsv_t;

  // Per-pixel context that rides along with the divider stages.
  typedef struct packed {
    comp_t   max;
    comp_t   delta;
    sector_t sector;
    logic    neg;
    logic    black;
    logic    grey;
  } div_ctx_t;

endpackage

// ===== src/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps

// Channel   Signals                        Direction  Contents
// pixel     pixel, pixel_valid, pixel_stall  in       red, green, blue
// hsv       hsv, hsv_valid, hsv_stall        out      hue, saturation, brightness
//
// One pixel is taken per clock while pixel_stall is low. Each pixel passes
// through every stage in order from its transfer to its result, and the two
// restoring dividers resolve one quotient bit per pipeline stage.
// Reset clears only the valid bits of the stages.
// Empty stages fill while the output stalls, so pixel_stall rises only when
// every stage holds a pixel and the result at the output is not taken.

module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  pixel_t pixel,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  output hsv_t   hsv,
  output logic   hsv_valid,
  input  logic   hsv_stall
);

  // Stage 0 finds max, min and the hue sector, stage 1 builds the dividends,
  // then QUO_W divider stages follow and the last stage is the output.
  localparam int NST = QUO_W + 3;

  logic [NST-1:0] stage_valid;
  logic [NST-1:0] en;

  // Stage 0 registers.
  logic                           a_valid;
  comp_t                          a_max;
  comp_t                          a_min;
  sector_t                        a_sector;
  logic signed [COMPONENT_BITS:0] a_diff;

  // Divider chain: index 0 is loaded by stage 1, index k + 1 by divider
  // stage k.
  logic             d_valid [0:QUO_W];
  logic [REM_W-1:0] s_rem   [0:QUO_W];
  logic [REM_W-1:0] h_rem   [0:QUO_W];
  logic [QUO_W-1:0] s_quo   [0:QUO_W];
  logic [QUO_W-1:0] h_quo   [0:QUO_W];
  div_ctx_t         d_ctx   [0:QUO_W];

  // Stage 0 next values.
  comp_t                          a_max_next;
  comp_t                          a_min_next;
  sector_t                        a_sector_next;
  logic signed [COMPONENT_BITS:0] a_diff_next;

  // Stage 1 next values.
  logic [COMPONENT_BITS:0] abs_diff_wide;
  comp_t                   abs_diff;
  comp_t                   delta;
  div_ctx_t                b_ctx_next;
  logic [REM_W-1:0]        s_num_next;
  logic [REM_W-1:0]        h_num_next;

  // Output stage.
  logic signed [HUE_SUM_W-1:0] hue_base;
  logic signed [HUE_SUM_W-1:0] hue_frac;
  logic signed [HUE_SUM_W-1:0] hue_sum;
  hsv_t                        hsv_next;

  // A stage may load when it is empty or when the stage after it moves on.
  // That is the case unless this stage and every later one hold a pixel and
  // the output is stalled.
  always_comb begin
    stage_valid[0] = a_valid;
    for (int k = 0; k <= QUO_W; k++) begin
      stage_valid[k + 1] = d_valid[k];
    end
    stage_valid[NST-1] = hsv_valid;
    for (int k = 0; k < NST; k++) begin
      en[k] = !hsv_stall ||
              !(&(stage_valid | ((NST'(1) << k) - NST'(1))));
    end
  end

  assign pixel_stall = !en[0];

  // Stage 0: largest and smallest component. Ties go to red, then green.
  always_comb begin
    a_max_next    = pixel.red;
    a_sector_next = SECTOR_RED;
    if (pixel.green > a_max_next) begin
      a_max_next    = pixel.green;
      a_sector_next = SECTOR_GREEN;
    end
    if (pixel.blue > a_max_next) begin
      a_max_next    = pixel.blue;
      a_sector_next = SECTOR_BLUE;
    end
    a_min_next = pixel.red;
    if (pixel.green < a_min_next) begin
      a_min_next = pixel.green;
    end
    if (pixel.blue < a_min_next) begin
      a_min_next = pixel.blue;
    end
    case (a_sector_next)
      SECTOR_RED: begin
        a_diff_next = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
      end
      SECTOR_GREEN: begin
        a_diff_next = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
      end
      default: begin
        a_diff_next = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en[0]) begin
      a_valid <= pixel_valid;
    end
    if (en[0]) begin
      a_max    <= a_max_next;
      a_min    <= a_min_next;
      a_sector <= a_sector_next;
      a_diff   <= a_diff_next;
    end
  end

  // Stage 1: the dividends. FULL_SCALE * delta and 60 * |diff| are built
  // from shifts, since both factors are constant.
  always_comb begin
    delta         = a_max - a_min;
    abs_diff_wide = a_diff[COMPONENT_BITS] ? -a_diff : a_diff;
    abs_diff      = abs_diff_wide[COMPONENT_BITS-1:0];

    b_ctx_next.max    = a_max;
    b_ctx_next.delta  = delta;
    b_ctx_next.sector = a_sector;
    b_ctx_next.neg    = a_diff[COMPONENT_BITS];
    b_ctx_next.black  = (a_max == '0);
    b_ctx_next.grey   = (delta == '0);

    s_num_next = (REM_W'(delta) << COMPONENT_BITS) - REM_W'(delta);
    h_num_next = (REM_W'(abs_diff) << 6) - (REM_W'(abs_diff) << 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (en[1]) begin
      d_valid[0] <= a_valid;
    end
    if (en[1]) begin
      d_ctx[0] <= b_ctx_next;
      s_rem[0] <= s_num_next;
      h_rem[0] <= h_num_next;
      s_quo[0] <= '0;
      h_quo[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  // Saturation divides by max and hue by delta. A zero divisor gives a
  // meaningless quotient here, which the output stage replaces.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int QBIT = QUO_W - 1 - j;

    logic [REM_W-1:0] s_sub;
    logic [REM_W-1:0] h_sub;
    logic             s_take;
    logic             h_take;

    always_comb begin
      s_sub  = REM_W'(d_ctx[j].max) << QBIT;
      h_sub  = REM_W'(d_ctx[j].delta) << QBIT;
      s_take = (s_rem[j] >= s_sub);
      h_take = (h_rem[j] >= h_sub);
    end

    // The quotient bit of this stage is still clear on arrival.
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[j + 1] <= 1'b0;
      end else if (en[j + 2]) begin
        d_valid[j + 1] <= d_valid[j];
      end
      if (en[j + 2]) begin
        d_ctx[j + 1] <= d_ctx[j];
        s_rem[j + 1] <= s_take ? (s_rem[j] - s_sub) : s_rem[j];
        h_rem[j + 1] <= h_take ? (h_rem[j] - h_sub) : h_rem[j];
        s_quo[j + 1] <= s_quo[j] | (QUO_W'(s_take) << QBIT);
        h_quo[j + 1] <= h_quo[j] | (QUO_W'(h_take) << QBIT);
      end
    end
  end

  // Output stage: hue is the sector base plus the floor of 60 * diff / delta.
  // A negative difference rounds the fraction away from zero when a
  // remainder is left, and a hue below zero wraps by a full turn.
  always_comb begin
    case (d_ctx[QUO_W].sector)
      SECTOR_RED:   hue_base = '0;
      SECTOR_GREEN: hue_base = HUE_SUM_W'(DEG_GREEN);
      default:      hue_base = HUE_SUM_W'(DEG_BLUE);
    endcase
    if (d_ctx[QUO_W].neg) begin
      hue_frac = -(HUE_SUM_W'(h_quo[QUO_W]) + HUE_SUM_W'(h_rem[QUO_W] != '0));
    end else begin
      hue_frac = HUE_SUM_W'(h_quo[QUO_W]);
    end
    hue_sum = hue_base + hue_frac;
    if (hue_sum < 0) begin
      hue_sum = hue_sum + HUE_SUM_W'(DEG_FULL);
    end

    hsv_next.hue = (d_ctx[QUO_W].black || d_ctx[QUO_W].grey) ? '0 :
                   hue_sum[HUE_W-1:0];
    hsv_next.saturation = d_ctx[QUO_W].black ? '0 :
                          s_quo[QUO_W][COMPONENT_BITS-1:0];
    hsv_next.brightness = d_ctx[QUO_W].max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en[NST-1]) begin
      hsv_valid <= d_valid[QUO_W];
    end
    if (en[NST-1]) begin
      hsv <= hsv_next;
    end
  end

`ifndef SYNTH
  // The input stalls only when every stage is full and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> ((&stage_valid) && hsv_stall))
    else $error("input stalled while the pipeline had room");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && (hsv.brightness == '0)) |->
      ((hsv.hue == '0) && (hsv.saturation == '0)))
    else $error("black pixel gave a nonzero hue or saturation");

  // Any nonzero delta gives saturation of at least one, so zero means grey.
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && (hsv.saturation == '0)) |-> (hsv.hue == '0))
    else $error("unsaturated pixel gave a nonzero hue");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.hue < HUE_W'(DEG_FULL)))
    else $error("hue out of range");
`endif

endmodule

// ===== tb/hsv_checker.sv =====
`timescale 1ns / 1ps

module hsv_checker
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  pixel_t pixel,
  input  logic   pixel_valid,
  input  logic   pixel_stall,
  input  hsv_t   hsv,
  input  logic   hsv_valid,
  input  logic   hsv_stall,
  output int     mismatches,
  output int     hsv_pending
);

  // Expected conversions, oldest first, in the order the pixels were taken.
  hsv_t hsv_due[$];

  function automatic hsv_t hsv_of_pixel(pixel_t p);
    longint  r, g, b, mx, mn, delta, offset, diff, num, hue;
    sector_t sector;
    hsv_t    res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    res.saturation = '0;
    if (mx != 0) begin
      res.saturation = comp_t'((FULL_SCALE * delta) / mx);
      if (delta != 0) begin
        // Ties resolve toward red first, then green.
        if (r == mx) sector = SECTOR_RED;
        else if (g == mx) sector = SECTOR_GREEN;
        else sector = SECTOR_BLUE;
        case (sector)
          SECTOR_RED: begin
            offset = 0;
            diff = g - b;
          end
          SECTOR_GREEN: begin
            offset = 2;
            diff = b - r;
          end
          default: begin
            offset = 4;
            diff = r - g;
          end
        endcase
        num = DEG_SECTOR * (offset * delta + diff);
        // Floor toward minus infinity, not toward zero.
        if (num >= 0) hue = num / delta;
        else hue = -((-num + delta - 1) / delta);
        if (hue < 0) hue = hue + DEG_FULL;
      end
    end
    res.hue = hue[HUE_W-1:0];
    res.brightness = mx[COMPONENT_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("hsv mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    hsv_pending = 0;
  end

  always @(posedge clk) begin : watch
    hsv_t want;
    if (!rst) begin
      // The result side is handled first: a pixel taken on this edge cannot
      // have produced the result leaving on the same edge.
      if (hsv_valid && !hsv_stall) begin
        if (hsv_due.size() == 0) begin
          report_mismatch($sformatf("result h=%0d s=%0d v=%0d with nothing expected",
                                    hsv.hue, hsv.saturation, hsv.brightness));
        end else begin
          want = hsv_due.pop_front();
          if (hsv.hue !== want.hue)
            report_mismatch($sformatf("hue %0d, expected %0d", hsv.hue, want.hue));
          if (hsv.saturation !== want.saturation)
            report_mismatch($sformatf("saturation %0d, expected %0d",
                                      hsv.saturation, want.saturation));
          if (hsv.brightness !== want.brightness)
            report_mismatch($sformatf("brightness %0d, expected %0d",
                                      hsv.brightness, want.brightness));
        end
      end
      if (pixel_valid && !pixel_stall) hsv_due.push_back(hsv_of_pixel(pixel));
      hsv_pending = hsv_due.size();
    end
  end

endmodule

// ===== tb/rgb_to_hsv_converter_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;
  import rgbhsv_pkg::*;

  // Random pixels after the directed set; the last stretch of them runs
  // with neither side idling so the pipeline is exercised at full rate.
  localparam int RANDOM_PIXELS = 600;
  localparam int CALM_TAIL     = 100;
  // Stage count of the block's pipeline.
  localparam int LATENCY       = QUO_W + 3;

  localparam comp_t C_ZERO = comp_t'(0);
  localparam comp_t C_ONE  = comp_t'(1);
  localparam comp_t C_HALF = comp_t'(FULL_SCALE / 2 + 1);
  localparam comp_t C_TOP  = comp_t'(FULL_SCALE);
  localparam comp_t C_NEAR = comp_t'(FULL_SCALE - 1);

  logic   clk = 1'b0;
  logic   rst;
  pixel_t pixel;
  logic   pixel_valid;
  logic   pixel_stall;
  hsv_t   hsv;
  logic   hsv_valid;
  logic   hsv_stall;

  int mismatches;
  int hsv_pending;
  // Set for the final stretch: no gaps from the source, no stalls at the sink.
  bit calm = 1'b0;

  always #4 clk = ~clk;

  rgb_to_hsv_converter dut (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .hsv        (hsv),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall)
  );

  // The checker sits beside the block, watches both channels and keeps the
  // running mismatch count; this module only makes traffic and decides.
  hsv_checker u_hsv_check (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .hsv        (hsv),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .mismatches (mismatches),
    .hsv_pending(hsv_pending)
  );

  function automatic comp_t rand_comp();
    return comp_t'($urandom);
  endfunction

  // A component pulled from the corners of the range.
  function automatic comp_t corner_comp();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return C_ZERO;
      1: return C_ONE;
      2: return C_NEAR;
      default: return C_TOP;
    endcase
  endfunction

  // Most pixels are fully random, but a good share is steered toward the
  // interesting corners of the conversion: greys, ties for the largest
  // component, tiny deltas and saturated colors.
  function automatic pixel_t random_pixel();
    int     kind, tie_pick, lo;
    comp_t  hi, other;
    pixel_t p;
    kind = $urandom_range(0, 9);
    p = {rand_comp(), rand_comp(), rand_comp()};
    case (kind)
      4: begin
        hi = rand_comp();
        p = {hi, hi, hi};
      end
      5: begin
        hi = rand_comp();
        other = comp_t'($urandom_range(0, hi));
        tie_pick = $urandom_range(0, 2);
        case (tie_pick)
          0: p = {hi, hi, other};
          1: p = {hi, other, hi};
          default: p = {other, hi, hi};
        endcase
      end
      6: begin
        hi = rand_comp();
        lo = int'(hi) - $urandom_range(0, 3);
        p.red = hi;
        p.green = comp_t'((lo < 0) ? 0 : lo);
        lo = int'(hi) - $urandom_range(0, 3);
        p.blue = comp_t'((lo < 0) ? 0 : lo);
        tie_pick = $urandom_range(0, 2);
        if (tie_pick == 1) p = {p.green, p.red, p.blue};
        if (tie_pick == 2) p = {p.blue, p.green, p.red};
      end
      7: p = {corner_comp(), corner_comp(), corner_comp()};
      8: begin
        if ($urandom_range(0, 1) == 0) p.red = C_ZERO;
        if ($urandom_range(0, 1) == 0) p.green = C_ZERO;
        if ($urandom_range(0, 1) == 0) p.blue = C_ZERO;
      end
      default: ;
    endcase
    return p;
  endfunction

  // Present one pixel at the falling edge and hold it until a rising edge
  // sees the transfer. The next call or an idle stretch replaces it at the
  // following falling edge, so valid is never dropped and raised in one step.
  task automatic send_pixel(pixel_t p);
    @(negedge clk);
    pixel <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
  endtask

  task automatic send_rgb(comp_t r, comp_t g, comp_t b);
    send_pixel({r, g, b});
  endtask

  // Leave the pixel channel empty for the given number of cycles. The payload is scrambled
  // while valid is low, which the block has to ignore.
  task automatic idle_pixels(int cycles);
    @(negedge clk);
    pixel_valid <= 1'b0;
    pixel <= {rand_comp(), rand_comp(), rand_comp()};
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Result side back-pressure: runs of open cycles, sometimes long ones,
  // broken by stall bursts until the calm tail begins.
  initial begin : sink_stall
    int run, len;
    hsv_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      repeat (run) begin
        @(negedge clk);
        hsv_stall <= 1'b0;
      end
      if (!calm) begin
        len = $urandom_range(1, 17);
        repeat (len) begin
          @(negedge clk);
          hsv_stall <= 1'b1;
        end
      end
    end
  end

  // Hard stop. The slowest correct run is far below this even with every
  // gap and every stall at its longest.
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    pixel = '0;
    pixel_valid = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Black, white and greys: saturation and hue must both come out zero,
    // and black must give zero brightness too.
    send_rgb(C_ZERO, C_ZERO, C_ZERO);
    send_rgb(C_TOP, C_TOP, C_TOP);
    send_rgb(C_HALF, C_HALF, C_HALF);
    send_rgb(C_ONE, C_ONE, C_ONE);
    // Pure primaries at both ends of the range.
    send_rgb(C_TOP, C_ZERO, C_ZERO);
    send_rgb(C_ZERO, C_TOP, C_ZERO);
    send_rgb(C_ZERO, C_ZERO, C_TOP);
    send_rgb(C_ONE, C_ZERO, C_ZERO);
    send_rgb(C_ZERO, C_ONE, C_ZERO);
    send_rgb(C_ZERO, C_ZERO, C_ONE);
    // Ties for the largest component: red beats green, green beats blue,
    // and red beats blue, which also sends the red sector negative.
    send_rgb(C_TOP, C_TOP, C_ZERO);
    send_rgb(C_ZERO, C_TOP, C_TOP);
    send_rgb(C_TOP, C_ZERO, C_TOP);
    // Red largest with blue above green: with blue just above green the floor must
    // land on 359 after the wrap, not on zero.
    send_rgb(C_TOP, C_ZERO, C_ONE);
    send_rgb(C_TOP, C_ZERO, C_NEAR);
    // Neighbors of the sector boundaries.
    send_rgb(C_TOP, C_NEAR, C_ZERO);
    send_rgb(C_NEAR, C_TOP, C_ZERO);
    send_rgb(C_ZERO, C_NEAR, C_TOP);
    send_rgb(C_ONE, C_ZERO, C_TOP);
    send_rgb(C_TOP, C_ONE, C_ZERO);
    send_rgb(C_ONE, C_TOP, C_NEAR);
    // Smallest nonzero delta at the top of the range.
    send_rgb(C_TOP, C_TOP, C_NEAR);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      calm = (i >= RANDOM_PIXELS - CALM_TAIL);
      if (!calm && $urandom_range(0, 3) == 0) idle_pixels($urandom_range(1, 17));
      send_pixel(random_pixel());
    end

    @(negedge clk);
    pixel_valid <= 1'b0;
    // Let every outstanding conversion drain, then keep watching the result
    // channel so that any stray result can show.
    while (hsv_pending != 0) @(negedge clk);
    repeat (3 * LATENCY) @(negedge clk);

    if (mismatches == 0 && hsv_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_converter.f =====
src/rgbhsv_pkg.sv
src/rgb_to_hsv_converter.sv
tb/hsv_checker.sv
tb/rgb_to_hsv_converter_tb.sv
